/* rtl/core/gclw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gclw_pkg
// Shared constants of the grid line cell walker: default coordinate format,
// cell width, register indexes and result queue size.
// ----------------------------------------------------------------------------
package gclw_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 8;
	localparam int CELL_BITS      = 12;

	localparam int CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_END_X   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_END_Y   = 3'd3;

	localparam int RES_PTR_BITS = 3;
	localparam int RES_DEPTH    = 1 << RES_PTR_BITS;

endpackage

/* rtl/core/grid_line_cell_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_cell_walker
// Walks the grid cells crossed by the segment from the start point toward the
// end point, one cell per request. A request with restart set, or the first
// request after reset, returns the start cell and loads the walk from the
// configuration registers; any other request steps to the next cell through
// the nearer vertical or horizontal grid line, stepping in x on a tie. The
// block takes one request per clock while req_stall is low. Results wait in an
// eight-entry queue, and req_stall rises while eight requests are taken and
// not yet delivered. Configuration writes reach the walk through three
// register stages of slope and product set-up, which the request path matches,
// so a request may follow a write at once.
// ----------------------------------------------------------------------------
module grid_line_cell_walker #(
	parameter int COORD_BITS = gclw_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = gclw_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [gclw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [COORD_BITS-1:0]                 cfg_data,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  restart,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [gclw_pkg::CELL_BITS-1:0] cell_x,
	output logic signed [gclw_pkg::CELL_BITS-1:0] cell_y
);

	localparam int CB    = COORD_BITS;
	localparam int FB    = FRAC_BITS;
	localparam int CW    = gclw_pkg::CELL_BITS;
	localparam int SW0   = (CB > CW) ? CB : CW;
	localparam int SW    = ((SW0 > FB) ? SW0 : FB) + 1;
	localparam int PW    = FB + 1 + CB;
	localparam int DW    = PW + 1;
	localparam int PB    = gclw_pkg::RES_PTR_BITS;
	localparam int CNT_W = PB + 1;

	localparam logic signed [CW-1:0] CELL_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CELL_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] CELL_MAX_W = SW'(CELL_MAX);
	localparam logic signed [SW-1:0] CELL_MIN_W = SW'(CELL_MIN);
	localparam logic [SW-1:0] FRAC_MASK = SW'((1 << FB) - 1);
	localparam logic [FB:0]   ONE_UNIT  = (FB + 1)'(1 << FB);

	// configuration registers
	logic signed [CB-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

	// walk set-up, stage a
	logic signed [CB:0] dx_q, dy_q;

	// walk set-up, stage b
	logic [CB-1:0]        ax_q, ay_q;
	logic                 sx_neg_q, sy_neg_q, x_only_q, y_only_q;
	logic [FB:0]          dist_x_q, dist_y_q;
	logic signed [CW-1:0] cell0_x_q, cell0_y_q;

	// walk set-up, stage c
	logic [PW-1:0] px_q, py_q;

	// request pipeline
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic restart_s1, restart_s2, restart_s3, restart_s4;

	// walk state
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic signed [DW-1:0] d_q;
	logic                 first_q;
	logic [CB-1:0]        wax_q, way_q;
	logic                 wsx_neg_q, wsy_neg_q, wx_only_q, wy_only_q;

	// result queue
	logic signed [CW-1:0] qx_q [gclw_pkg::RES_DEPTH];
	logic signed [CW-1:0] qy_q [gclw_pkg::RES_DEPTH];
	logic [PB:0]          wp_q, rp_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 req_take, res_take;
	logic signed [SW-1:0] sx_w, sy_w, fl_x, fl_y;
	logic [FB:0]          frac_x, frac_y;
	logic signed [CW-1:0] sat0_x, sat0_y;
	logic                 load;
	logic                 go_x;
	logic signed [DW-1:0] d0, inc_x, inc_y, nd;
	logic signed [CW-1:0] step_x, step_y, nx, ny;

	assign req_stall = (cnt_q == CNT_W'(gclw_pkg::RES_DEPTH));
	assign req_take  = req_valid & ~req_stall;
	assign res_valid = (wp_q != rp_q);
	assign res_take  = res_valid & ~res_stall;
	assign cell_x    = qx_q[rp_q[PB-1:0]];
	assign cell_y    = qy_q[rp_q[PB-1:0]];

	// start cell and distance to the first grid line
	always_comb begin
		sx_w   = SW'(start_x_q);
		sy_w   = SW'(start_y_q);
		fl_x   = sx_w >>> FB;
		fl_y   = sy_w >>> FB;
		frac_x = (FB + 1)'(sx_w & FRAC_MASK);
		frac_y = (FB + 1)'(sy_w & FRAC_MASK);
		if (fl_x > CELL_MAX_W) begin
			sat0_x = CELL_MAX;
		end else if (fl_x < CELL_MIN_W) begin
			sat0_x = CELL_MIN;
		end else begin
			sat0_x = CW'(fl_x);
		end
		if (fl_y > CELL_MAX_W) begin
			sat0_y = CELL_MAX;
		end else if (fl_y < CELL_MIN_W) begin
			sat0_y = CELL_MIN;
		end else begin
			sat0_y = CW'(fl_y);
		end
	end

	// one step of the walk
	always_comb begin
		load  = restart_s4 | first_q;
		d0    = $signed({1'b0, px_q}) - $signed({1'b0, py_q});
		inc_x = $signed(DW'(way_q) << FB);
		inc_y = $signed(DW'(wax_q) << FB);
		if (wy_only_q) begin
			go_x = 1'b0;
		end else if (wx_only_q) begin
			go_x = 1'b1;
		end else begin
			go_x = (d_q <= 0);
		end
		if (wsx_neg_q) begin
			step_x = (cur_x_q == CELL_MIN) ? cur_x_q : cur_x_q - CW'(1);
		end else begin
			step_x = (cur_x_q == CELL_MAX) ? cur_x_q : cur_x_q + CW'(1);
		end
		if (wsy_neg_q) begin
			step_y = (cur_y_q == CELL_MIN) ? cur_y_q : cur_y_q - CW'(1);
		end else begin
			step_y = (cur_y_q == CELL_MAX) ? cur_y_q : cur_y_q + CW'(1);
		end
		if (load) begin
			nx = cell0_x_q;
			ny = cell0_y_q;
			nd = d0;
		end else begin
			nx = go_x ? step_x : cur_x_q;
			ny = go_x ? cur_y_q : step_y;
			if (wx_only_q | wy_only_q) begin
				nd = d_q;
			end else begin
				nd = go_x ? d_q + inc_x : d_q - inc_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gclw_pkg::CFG_START_X: start_x_q <= cfg_data;
				gclw_pkg::CFG_START_Y: start_y_q <= cfg_data;
				gclw_pkg::CFG_END_X:   end_x_q   <= cfg_data;
				gclw_pkg::CFG_END_Y:   end_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// walk set-up pipeline, free running
	always_ff @(posedge clk) begin
		dx_q      <= (CB + 1)'(end_x_q) - (CB + 1)'(start_x_q);
		dy_q      <= (CB + 1)'(end_y_q) - (CB + 1)'(start_y_q);
		ax_q      <= CB'(dx_q[CB] ? -dx_q : dx_q);
		ay_q      <= CB'(dy_q[CB] ? -dy_q : dy_q);
		sx_neg_q  <= dx_q[CB];
		sy_neg_q  <= dy_q[CB];
		y_only_q  <= (dx_q == '0);
		x_only_q  <= (dx_q != '0) && (dy_q == '0);
		dist_x_q  <= dx_q[CB] ? frac_x : ONE_UNIT - frac_x;
		dist_y_q  <= dy_q[CB] ? frac_y : ONE_UNIT - frac_y;
		cell0_x_q <= sat0_x;
		cell0_y_q <= sat0_y;
		px_q      <= PW'(dist_x_q) * PW'(ay_q);
		py_q      <= PW'(dist_y_q) * PW'(ax_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			first_q  <= 1'b1;
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= req_take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s4) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
				first_q <= 1'b0;
				wp_q    <= wp_q + (PB + 1)'(1);
			end
			if (res_take) begin
				rp_q <= rp_q + (PB + 1)'(1);
			end
			cnt_q <= cnt_q + CNT_W'(req_take) - CNT_W'(res_take);
		end
	end

	always_ff @(posedge clk) begin
		restart_s1 <= restart;
		restart_s2 <= restart_s1;
		restart_s3 <= restart_s2;
		restart_s4 <= restart_s3;
		if (valid_s4) begin
			d_q <= nd;
			qx_q[wp_q[PB-1:0]] <= nx;
			qy_q[wp_q[PB-1:0]] <= ny;
			if (load) begin
				wax_q     <= ax_q;
				way_q     <= ay_q;
				wsx_neg_q <= sx_neg_q;
				wsy_neg_q <= sy_neg_q;
				wx_only_q <= x_only_q;
				wy_only_q <= y_only_q;
			end
		end
	end

endmodule
